### rtl/mes_pkg.sv
// shared types, constants and opcodes for the midi event scheduler
// no dependencies
`timescale 1ns / 1ps
package mes_pkg;

    // default sizing
    localparam int QUEUE_DEPTH_DEF       = 64;
    localparam int PORT_COUNT_DEF        = 8;
    localparam int TICKS_PER_QUARTER_DEF = 192;
    localparam int CMD_FIFO_DEPTH        = 4;

    // operation codes
    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // event kinds and result kinds
    localparam logic KIND_NOTE_ON    = 1'b0;
    localparam logic KIND_CONTROLLER = 1'b1;
    localparam logic RES_MESSAGE     = 1'b0;
    localparam logic RES_REJECT      = 1'b1;

    // midi status bases
    localparam logic [7:0] STATUS_NOTE_ON    = 8'h90;
    localparam logic [7:0] STATUS_CONTROLLER = 8'hB0;

    // register map
    localparam logic REG_TEMPO = 1'b0;
    localparam logic REG_RATE  = 1'b1;
    localparam logic [9:0]  TEMPO_RESET = 10'd120;
    localparam logic [17:0] RATE_RESET  = 18'd48000;

    typedef struct packed {
        logic [1:0]  operation;
        logic        event_kind;
        logic [3:0]  midi_channel;
        logic [6:0]  data_byte;
        logic [6:0]  value_byte;
        logic [31:0] due_tick;
        logic [2:0]  out_port;
        logic [15:0] note_length;
    } cmd_word_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  port_number;
        logic [7:0]  status_byte;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
    } rsp_word_t;

    // one stored event
    typedef struct packed {
        logic        kind;
        logic [3:0]  channel;
        logic [6:0]  data;
        logic [6:0]  value;
        logic [32:0] tick;
        logic [2:0]  port;
    } entry_t;

endpackage

### rtl/midi_event_scheduler.sv
// a sample tick scans every held entry and checks whether the earliest is due; a due entry
// is removed by shifting later entries down and emitted if its port is below PORT_COUNT
// one command runs at a time in the back end; a 4-word fifo takes words meanwhile
// the scan reads one stored entry per cycle from the event memory's dedicated read port
// reset: queue empty, counter zero, tempo 120, rate 48000; no clearing pass
`timescale 1ns / 1ps
module midi_event_scheduler
    import mes_pkg::*;
#(
    parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF,
    parameter int PORT_COUNT        = PORT_COUNT_DEF,
    parameter int TICKS_PER_QUARTER = TICKS_PER_QUARTER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_word_t   cmd,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_word_t   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [9:0]  tempo_reg;
    logic [17:0] rate_reg;
    logic        q_valid, q_pop;
    cmd_word_t   q_word;

    // configuration registers
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RATE) ? {14'd0, rate_reg} : {22'd0, tempo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg <= TEMPO_RESET;
            rate_reg  <= RATE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_TEMPO)
            begin
                tempo_reg <= pwdata[9:0];
            end
            else
            begin
                rate_reg <= pwdata[17:0];
            end
        end
    end

    // command intake
    mes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_word    (q_word)
    );

    // scheduling engine
    mes_engine #(
        .QUEUE_DEPTH       (QUEUE_DEPTH),
        .PORT_COUNT        (PORT_COUNT),
        .TICKS_PER_QUARTER (TICKS_PER_QUARTER)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .tempo_bpm   (tempo_reg),
        .sample_rate (rate_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_word      (q_word),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

### rtl/mes_front.sv
// front end: accepts command words, drops unused opcodes, buffers the rest
// depends on mes_pkg
`timescale 1ns / 1ps
module mes_front
    import mes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_word_t cmd,
    output logic      q_valid,
    input  logic      q_pop,
    output cmd_word_t q_word
);

    localparam int PW = $clog2(CMD_FIFO_DEPTH);
    localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_word_t         fifo_reg [CMD_FIFO_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              accept, push, pop;

    // classify: opcode 3 is consumed and dropped
    assign cmd_ready = (cnt_reg != CW'(CMD_FIFO_DEPTH));
    assign accept    = cmd_valid && cmd_ready;
    assign push      = accept && (cmd.operation != OP_UNUSED);
    assign pop       = q_pop && q_valid;
    assign q_valid   = (cnt_reg != '0);
    assign q_word    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

### rtl/mes_engine.sv
// back end: event store, earliest-entry scan, due check, compaction, result word
// depends on mes_pkg
`timescale 1ns / 1ps
module mes_engine
    import mes_pkg::*;
#(
    parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF,
    parameter int PORT_COUNT        = PORT_COUNT_DEF,
    parameter int TICKS_PER_QUARTER = TICKS_PER_QUARTER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [9:0]  tempo_bpm,
    input  logic [17:0] sample_rate,
    input  logic        q_valid,
    output logic        q_pop,
    input  cmd_word_t   q_word,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_word_t   rsp
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int A_W = $clog2(TICKS_PER_QUARTER * 1023 + 1);
    localparam int P_W = 24 + A_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCHED_OFF, ST_SCAN, ST_DUE_A, ST_DUE_LO, ST_DUE_HI,
        ST_DUE_RHS, ST_DUE_SUM, ST_DUE_CMP, ST_MV_RD, ST_MV_WR, ST_EMIT
    } state_t;

    state_t          state_reg;
    cmd_word_t       cmd_reg;
    logic [CW-1:0]   count_reg;
    logic [47:0]     sample_reg;
    logic [CW-1:0]   issue_reg, cmp_idx_reg, best_idx_reg, mv_reg;
    logic            cmp_vld_reg;
    entry_t          best_reg;
    logic [A_W-1:0]  a_reg;
    logic [P_W-1:0]  p_lo_reg, p_hi_reg;
    logic [50:0]     r1_reg;
    logic [63:0]     lhs_reg, rhs_reg;
    logic            big_reg;
    rsp_word_t       res_reg, rsp_reg;
    logic            rsp_valid_reg;

    entry_t          mem [QUEUE_DEPTH];
    entry_t          rd_data_reg;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            wr_en;
    entry_t          wr_data;
    logic            issue, with_off, emit_go;
    logic [CW:0]     need_sum;
    logic [33:0]     off_tick;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign with_off  = (q_word.event_kind == KIND_NOTE_ON) && (q_word.value_byte != 7'd0);
    assign need_sum  = {1'b0, count_reg} + (with_off ? (CW+1)'(2) : (CW+1)'(1));
    assign issue     = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign emit_go   = !rsp_valid_reg || rsp_ready;
    assign off_tick  = {2'b0, cmd_reg.due_tick} + {18'd0, cmd_reg.note_length};

    // memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = rd_data_reg;
        rd_addr = issue_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                wr_en   = q_pop && (q_word.operation == OP_SCHEDULE)
                          && (need_sum <= (CW+1)'(QUEUE_DEPTH));
                wr_data = '{kind: q_word.event_kind, channel: q_word.midi_channel,
                            data: q_word.data_byte, value: q_word.value_byte,
                            tick: {1'b0, q_word.due_tick}, port: q_word.out_port};
            end
            ST_SCHED_OFF:
            begin
                wr_en   = 1'b1;
                wr_data = '{kind: cmd_reg.event_kind, channel: cmd_reg.midi_channel,
                            data: cmd_reg.data_byte, value: 7'd0,
                            tick: off_tick[32:0], port: cmd_reg.out_port};
            end
            ST_MV_RD:
            begin
                rd_addr = AW'(mv_reg + 1'b1);
            end
            ST_MV_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = mv_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // event store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer, arithmetic and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sample_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            issue_reg     <= '0;
            cmp_idx_reg   <= '0;
            best_idx_reg  <= '0;
            mv_reg        <= '0;
        end
        else
        begin
            // the emit state sets its own valid
            if (rsp_valid_reg && rsp_ready && (state_reg != ST_EMIT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_word;
                        unique case (q_word.operation)
                            OP_SCHEDULE:
                            begin
                                if (need_sum > (CW+1)'(QUEUE_DEPTH))
                                begin
                                    res_reg   <= '{result_kind: RES_REJECT, default: '0};
                                    state_reg <= ST_EMIT;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    if (with_off)
                                    begin
                                        state_reg <= ST_SCHED_OFF;
                                    end
                                end
                            end
                            OP_TICK:
                            begin
                                sample_reg  <= sample_reg + 48'd1;
                                issue_reg   <= '0;
                                cmp_vld_reg <= 1'b0;
                                if (count_reg != '0)
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            OP_RESTART:
                            begin
                                count_reg  <= '0;
                                sample_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCHED_OFF:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    // one read issued and one compared per cycle
                    cmp_vld_reg <= issue;
                    cmp_idx_reg <= issue_reg;
                    if (issue)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (cmp_vld_reg && ((cmp_idx_reg == '0) || (rd_data_reg.tick < best_reg.tick)))
                    begin
                        best_reg     <= rd_data_reg;
                        best_idx_reg <= cmp_idx_reg;
                    end
                    if (!issue && !cmp_vld_reg)
                    begin
                        state_reg <= ST_DUE_A;
                    end
                end
                ST_DUE_A:
                begin
                    a_reg     <= A_W'(A_W'(TICKS_PER_QUARTER) * A_W'(tempo_bpm));
                    state_reg <= ST_DUE_LO;
                end
                ST_DUE_LO:
                begin
                    p_lo_reg  <= P_W'(sample_reg[23:0]) * P_W'(a_reg);
                    state_reg <= ST_DUE_HI;
                end
                ST_DUE_HI:
                begin
                    p_hi_reg  <= P_W'(sample_reg[47:24]) * P_W'(a_reg);
                    state_reg <= ST_DUE_RHS;
                end
                ST_DUE_RHS:
                begin
                    r1_reg    <= 51'(best_reg.tick) * 51'(sample_rate);
                    state_reg <= ST_DUE_SUM;
                end
                ST_DUE_SUM:
                begin
                    // times 60 as 64x - 4x
                    rhs_reg   <= (64'(r1_reg) << 6) - (64'(r1_reg) << 2);
                    lhs_reg   <= (64'(p_hi_reg) << 24) + 64'(p_lo_reg);
                    big_reg   <= ((p_hi_reg >> 33) != '0);
                    state_reg <= ST_DUE_CMP;
                end
                ST_DUE_CMP:
                begin
                    res_reg <= '{result_kind: RES_MESSAGE,
                                 port_number: best_reg.port,
                                 status_byte: ((best_reg.kind == KIND_CONTROLLER)
                                               ? STATUS_CONTROLLER : STATUS_NOTE_ON)
                                              + {4'd0, best_reg.channel},
                                 first_data: best_reg.data,
                                 second_data: best_reg.value};
                    mv_reg    <= best_idx_reg;
                    state_reg <= (big_reg || (lhs_reg >= rhs_reg)) ? ST_MV_RD : ST_IDLE;
                end
                ST_MV_RD:
                begin
                    // close the gap left by the removed entry
                    if (CW'(mv_reg + 1'b1) < count_reg)
                    begin
                        state_reg <= ST_MV_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= ({{(32-3){1'b0}}, best_reg.port} < 32'(PORT_COUNT))
                                     ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_MV_WR:
                begin
                    mv_reg    <= mv_reg + 1'b1;
                    state_reg <= ST_MV_RD;
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
